// ===== hdl/hps_pkg.sv =====
// Shared types and constants of the haptic pulse sequencer.
`default_nettype none

package hps_pkg;

	localparam int LEVEL_BITS = 8;
	localparam int DIV_BITS   = 8;
	localparam int MAX_BITS   = 16;
	localparam int CFG_BITS   = 16;
	localparam int IDX_BITS   = 3;
	localparam int PHASE_BITS = 2;

	localparam logic [IDX_BITS-1:0] REG_DRIVE_LEVEL     = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_REVERSE_DIVISOR = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_REVERSE_MAX_MS  = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_BRAKE_DIVISOR   = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_BRAKE_MAX_MS    = 3'd4;

	localparam logic [PHASE_BITS-1:0] PH_ASLEEP  = 2'd0;
	localparam logic [PHASE_BITS-1:0] PH_FORWARD = 2'd1;
	localparam logic [PHASE_BITS-1:0] PH_REVERSE = 2'd2;
	localparam logic [PHASE_BITS-1:0] PH_BRAKE   = 2'd3;

	localparam logic [LEVEL_BITS-1:0] FULL_LEVEL = 8'd255;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] drive_level;
		logic [DIV_BITS-1:0]   reverse_divisor;
		logic [MAX_BITS-1:0]   reverse_max_ms;
		logic [DIV_BITS-1:0]   brake_divisor;
		logic [MAX_BITS-1:0]   brake_max_ms;
	} hps_cfg_t;

endpackage

`default_nettype wire

// ===== hdl/hps_cfg.sv =====
// Configuration register file of the haptic pulse sequencer.
`default_nettype none

module hps_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [hps_pkg::IDX_BITS-1:0] cfg_index,
	input  wire logic [hps_pkg::CFG_BITS-1:0] cfg_data,
	output hps_pkg::hps_cfg_t                 cfg
);

	hps_pkg::hps_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drive_level     <= 8'd254;
			cfg_q.reverse_divisor <= 8'd5;
			cfg_q.reverse_max_ms  <= 16'd8;
			cfg_q.brake_divisor   <= 8'd3;
			cfg_q.brake_max_ms    <= 16'd90;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hps_pkg::REG_DRIVE_LEVEL:
					cfg_q.drive_level <= cfg_data[hps_pkg::LEVEL_BITS-1:0];
				hps_pkg::REG_REVERSE_DIVISOR:
					cfg_q.reverse_divisor <= cfg_data[hps_pkg::DIV_BITS-1:0];
				hps_pkg::REG_REVERSE_MAX_MS:
					cfg_q.reverse_max_ms <= cfg_data[hps_pkg::MAX_BITS-1:0];
				hps_pkg::REG_BRAKE_DIVISOR:
					cfg_q.brake_divisor <= cfg_data[hps_pkg::DIV_BITS-1:0];
				hps_pkg::REG_BRAKE_MAX_MS:
					cfg_q.brake_max_ms <= cfg_data[hps_pkg::MAX_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/hps_div.sv =====
// Bit-serial restoring divider shared by the phase length calculations.
`default_nettype none

module hps_div #(
	parameter int DURATION_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [DURATION_BITS-1:0]     dividend,
	input  wire logic [hps_pkg::DIV_BITS-1:0] divisor,
	output logic                              done,
	output logic [DURATION_BITS-1:0]          quotient
);

	localparam int DB = hps_pkg::DIV_BITS;
	localparam int CNT_BITS = $clog2(DURATION_BITS + 1);

	logic [DURATION_BITS-1:0] quo_q;
	logic [DB-1:0]            rem_q;
	logic [DB-1:0]            dvs_q;
	logic [CNT_BITS-1:0]      cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [DB:0]              cand;
	logic                     fits;

	assign cand = {rem_q, quo_q[DURATION_BITS-1]};
	assign fits = (cand >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(DURATION_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, most significant first
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= (divisor == '0) ? DB'(1) : divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DURATION_BITS-2:0], fits};
			if (fits) begin
				rem_q <= DB'(cand - {1'b0, dvs_q});
			end else begin
				rem_q <= cand[DB-1:0];
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== hdl/haptic_pulse_sequencer.sv =====
// Top level of the haptic pulse sequencer: handshakes, phase sequencer and fault latch.
// A tick, or a pulse request while busy, gives its result in the cycle after acceptance.
// A pulse request while asleep runs two divisions in turn on the one bit-serial divider,
// one quotient bit per cycle, the brake length first and then the reverse length.
// One item is in work at a time; the next is taken once the result register is free.
// Reset clears phase, lengths, levels and fault latch and loads the register defaults.
`default_nettype none

module haptic_pulse_sequencer #(
	parameter int DURATION_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           req_type,
	input  wire logic [DURATION_BITS-1:0]       duration_ms,
	input  wire logic                           fault_n,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [hps_pkg::LEVEL_BITS-1:0]      chan_a_level,
	output logic [hps_pkg::LEVEL_BITS-1:0]      chan_b_level,
	output logic [hps_pkg::PHASE_BITS-1:0]      phase,
	output logic                                fault_latched,
	output logic                                fault_rise,
	input  wire logic                           cfg_we,
	input  wire logic [hps_pkg::IDX_BITS-1:0]   cfg_index,
	input  wire logic [hps_pkg::CFG_BITS-1:0]   cfg_data
);

	localparam int DW = DURATION_BITS;
	localparam int LW = hps_pkg::LEVEL_BITS;
	localparam int CW = (DURATION_BITS > hps_pkg::MAX_BITS) ? DURATION_BITS : hps_pkg::MAX_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BDIV = 2'd1;
	localparam logic [1:0] ST_RDIV = 2'd2;

	hps_pkg::hps_cfg_t cfg;

	logic [1:0]                       st_q;
	logic [hps_pkg::PHASE_BITS-1:0]   phase_q;
	logic [DW-1:0]                    time_left_q;
	logic [DW-1:0]                    reverse_len_q;
	logic [DW-1:0]                    brake_len_q;
	logic [DW-1:0]                    d_q;
	logic [LW-1:0]                    level_a_q;
	logic [LW-1:0]                    level_b_q;
	logic                             sticky_q;
	logic                             prev_q;
	logic                             rise_q;
	logic                             out_valid_q;

	logic                             accept;
	logic                             asserted;
	logic                             sticky_nx;
	logic                             start_pulse;
	logic                             item_done;

	logic                             div_start;
	logic [DW-1:0]                    div_dividend;
	logic [hps_pkg::DIV_BITS-1:0]     div_divisor;
	logic                             div_done;
	logic [DW-1:0]                    div_quo;

	logic [DW-1:0]                    clamped;
	logic [CW-1:0]                    quo_ext;
	logic [CW-1:0]                    max_ext;
	logic [DW-1:0]                    d_rest;

	logic [DW-1:0]                    tl_dec;
	logic [hps_pkg::PHASE_BITS-1:0]   ph_tk;
	logic [DW-1:0]                    tl_tk;
	logic [LW-1:0]                    la_tk;
	logic [LW-1:0]                    lb_tk;
	logic                             wr_tk;

	hps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hps_div #(
		.DURATION_BITS (DURATION_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign in_stall    = (st_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept      = in_valid && !in_stall;
	assign asserted    = !fault_n;
	assign sticky_nx   = sticky_q || asserted;
	assign start_pulse = accept && req_type && (phase_q == hps_pkg::PH_ASLEEP);
	// a result is ready on a plain transaction or at the end of the second division
	assign item_done   = (accept && !start_pulse) || (st_q == ST_RDIV && div_done);

	// clamp the fresh quotient against the limit of the current division
	always_comb begin
		quo_ext = CW'(div_quo);
		if (st_q == ST_BDIV) begin
			max_ext = CW'(cfg.brake_max_ms);
		end else begin
			max_ext = CW'(cfg.reverse_max_ms);
		end
		if (quo_ext > max_ext) begin
			clamped = max_ext[DW-1:0];
		end else begin
			clamped = div_quo;
		end
		d_rest = d_q - clamped;
	end

	// the first division starts on the request, the second as the first ends
	always_comb begin
		div_start    = start_pulse || (st_q == ST_BDIV && div_done);
		div_dividend = start_pulse ? duration_ms : d_rest;
		div_divisor  = start_pulse ? cfg.brake_divisor : cfg.reverse_divisor;
	end

	always_comb begin
		tl_dec = (time_left_q != '0) ? time_left_q - DW'(1) : time_left_q;
		ph_tk  = phase_q;
		tl_tk  = tl_dec;
		la_tk  = hps_pkg::FULL_LEVEL;
		lb_tk  = hps_pkg::FULL_LEVEL;
		wr_tk  = 1'b0;
		if (phase_q != hps_pkg::PH_ASLEEP && tl_dec == '0) begin
			wr_tk = 1'b1;
			unique case (phase_q)
				hps_pkg::PH_FORWARD: begin
					ph_tk = hps_pkg::PH_REVERSE;
					tl_tk = reverse_len_q;
					la_tk = '0;
				end
				hps_pkg::PH_REVERSE: begin
					ph_tk = hps_pkg::PH_BRAKE;
					tl_tk = brake_len_q;
				end
				default: begin
					ph_tk = hps_pkg::PH_ASLEEP;
					tl_tk = '0;
					la_tk = '0;
					lb_tk = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			phase_q       <= hps_pkg::PH_ASLEEP;
			time_left_q   <= '0;
			reverse_len_q <= '0;
			brake_len_q   <= '0;
			level_a_q     <= '0;
			level_b_q     <= '0;
			sticky_q      <= 1'b0;
			prev_q        <= 1'b0;
			rise_q        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (item_done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						// sample the fault pin before handling the transaction
						sticky_q <= sticky_nx;
						prev_q   <= asserted;
						rise_q   <= asserted && !prev_q;
						if (start_pulse) begin
							st_q <= ST_BDIV;
						end else begin
							if (!req_type) begin
								phase_q     <= ph_tk;
								time_left_q <= tl_tk;
								if (wr_tk) begin
									level_a_q <= sticky_nx ? '0 : la_tk;
									level_b_q <= sticky_nx ? '0 : lb_tk;
								end
							end
						end
					end
				end
				ST_BDIV: begin
					if (div_done) begin
						brake_len_q <= clamped;
						st_q        <= ST_RDIV;
					end
				end
				ST_RDIV: begin
					if (div_done) begin
						reverse_len_q <= clamped;
						time_left_q   <= d_rest;
						phase_q       <= hps_pkg::PH_FORWARD;
						level_a_q     <= sticky_q ? '0 : cfg.drive_level;
						level_b_q     <= '0;
						st_q          <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// remaining duration: request value, then less the brake length
	always_ff @(posedge clk) begin
		if (start_pulse) begin
			d_q <= duration_ms;
		end else if (st_q == ST_BDIV && div_done) begin
			d_q <= d_rest;
		end
	end

	assign out_valid     = out_valid_q;
	assign chan_a_level  = level_a_q;
	assign chan_b_level  = level_b_q;
	assign phase         = phase_q;
	assign fault_latched = sticky_q;
	assign fault_rise    = rise_q;

endmodule

`default_nettype wire
